>>> design/tifv_pkg.sv
package tifv_pkg;

  // Entry geometry
  localparam int unsigned BUF_DEPTH  = 20;
  localparam int unsigned POS_W      = 5;
  localparam logic [POS_W-1:0] ENTRY_LEN_CLASSIC = 5'd12;
  localparam logic [POS_W-1:0] ENTRY_LEN_BIG     = 5'd20;
  localparam logic [3:0] INL_CAP_CLASSIC = 4'd4;
  localparam logic [3:0] INL_CAP_BIG     = 4'd8;

  // TIFF field type codes
  localparam logic [15:0] FT_NONE       = 16'd0;
  localparam logic [15:0] FT_BYTE       = 16'd1;
  localparam logic [15:0] FT_ASCII      = 16'd2;
  localparam logic [15:0] FT_SHORT      = 16'd3;
  localparam logic [15:0] FT_LONG       = 16'd4;
  localparam logic [15:0] FT_RATIONAL   = 16'd5;
  localparam logic [15:0] FT_SBYTE      = 16'd6;
  localparam logic [15:0] FT_UNDEFINED  = 16'd7;
  localparam logic [15:0] FT_SSHORT     = 16'd8;
  localparam logic [15:0] FT_SLONG      = 16'd9;
  localparam logic [15:0] FT_SRATIONAL  = 16'd10;
  localparam logic [15:0] FT_FLOAT      = 16'd11;
  localparam logic [15:0] FT_DOUBLE     = 16'd12;
  localparam logic [15:0] FT_IFD        = 16'd13;
  localparam logic [15:0] FT_UNASSIGNED = 16'd14;
  localparam logic [15:0] FT_LONG8      = 16'd16;
  localparam logic [15:0] FT_SLONG8     = 16'd17;
  localparam logic [15:0] FT_IFD8       = 16'd18;
  // classic files only know codes below this one
  localparam logic [15:0] FT_CLASSIC_END = 16'd16;

  // Tags with special limit handling
  localparam logic [15:0] TAG_ICC            = 16'd34675;
  localparam logic [15:0] TAG_STRIP_OFS      = 16'd273;
  localparam logic [15:0] TAG_STRIP_COUNTS   = 16'd279;
  localparam logic [15:0] TAG_TILE_OFS       = 16'd324;
  localparam logic [15:0] TAG_TILE_COUNTS    = 16'd325;

  // Config register reset values
  localparam logic [63:0] RST_HEADER_SIZE = 64'd8;
  localparam logic [63:0] RST_FILE_SIZE   = 64'd0;
  localparam logic [63:0] RST_MAX_ICC     = 64'd16777216;
  localparam logic [63:0] RST_MAX_TAG     = 64'd1048576;

  typedef enum logic [2:0] {
    REG_BIG_ENDIAN   = 3'd0,
    REG_BIGTIFF_MODE = 3'd1,
    REG_HEADER_SIZE  = 3'd2,
    REG_FILE_SIZE    = 3'd3,
    REG_MAX_ICC      = 3'd4,
    REG_MAX_TAG      = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_INVALID = 2'd1,
    STS_LIMIT   = 2'd2,
    STS_BOUNDS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_DECODE,
    ST_CHECK
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;
    logic decode;
    logic load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_byte;
    logic out_free;
  } sts_t;

endpackage

>>> design/tifv_ctrl.sv
module tifv_ctrl
  import tifv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_valid && sts.last_byte) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.out_free) begin
          state_nxt = ST_FILL;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.take_byte = 1'b0;
    cmd.decode    = 1'b0;
    cmd.load      = 1'b0;
    unique case (state_r)
      ST_FILL: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
      end
      ST_CHECK: begin
        cmd.load = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> design/tifv_dp.sv
module tifv_dp
  import tifv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [7:0]  in_entry_byte,
  input  logic        in_entry_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_tag_number,
  output logic [15:0] out_field_type,
  output logic [63:0] out_element_count,
  output logic [63:0] out_byte_total,
  output logic [63:0] out_value_word,
  output logic [63:0] out_inline_raw,
  output logic        out_is_inline
);

  // config registers
  logic        big_endian_r;
  logic        bigtiff_r;
  logic [63:0] header_size_r;
  logic [63:0] file_size_r;
  logic [63:0] max_icc_r;
  logic [63:0] max_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r  <= 1'b0;
      bigtiff_r     <= 1'b0;
      header_size_r <= RST_HEADER_SIZE;
      file_size_r   <= RST_FILE_SIZE;
      max_icc_r     <= RST_MAX_ICC;
      max_tag_r     <= RST_MAX_TAG;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_BIG_ENDIAN:   big_endian_r  <= cfg_data[0];
        REG_BIGTIFF_MODE: bigtiff_r     <= cfg_data[0];
        REG_HEADER_SIZE:  header_size_r <= cfg_data;
        REG_FILE_SIZE:    file_size_r   <= cfg_data;
        REG_MAX_ICC:      max_icc_r     <= cfg_data;
        REG_MAX_TAG:      max_tag_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // byte capture
  logic [7:0]       ebuf_r [BUF_DEPTH];
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [POS_W-1:0] wr_idx;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] entry_len;

  assign wr_idx        = in_entry_start ? '0 : pos_r;
  assign pos_inc       = wr_idx + 5'd1;
  assign entry_len     = bigtiff_r ? ENTRY_LEN_BIG : ENTRY_LEN_CLASSIC;
  assign sts.last_byte = (pos_inc >= entry_len);
  assign pos_nxt       = sts.last_byte ? '0 : pos_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.take_byte) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      ebuf_r[wr_idx] <= in_entry_byte;
    end
  end

  // decode stage: byte order, width, byte total
  logic [15:0] tag_c, type_c;
  logic [63:0] count_c, value_c, raw_c, total_c;
  logic [1:0]  wshift_c;
  logic        wzero_c, ovf_c, bad_c, inl_c;

  always_comb begin
    count_c = '0;
    value_c = '0;
    raw_c   = '0;
    if (big_endian_r) begin
      tag_c  = {ebuf_r[0], ebuf_r[1]};
      type_c = {ebuf_r[2], ebuf_r[3]};
    end else begin
      tag_c  = {ebuf_r[1], ebuf_r[0]};
      type_c = {ebuf_r[3], ebuf_r[2]};
    end
    if (bigtiff_r) begin
      for (int i = 0; i < 8; i++) begin
        raw_c[8*i +: 8] = ebuf_r[POS_W'(12 + i)];
        if (big_endian_r) begin
          count_c[8*i +: 8] = ebuf_r[POS_W'(11 - i)];
          value_c[8*i +: 8] = ebuf_r[POS_W'(19 - i)];
        end else begin
          count_c[8*i +: 8] = ebuf_r[POS_W'(4 + i)];
          value_c[8*i +: 8] = ebuf_r[POS_W'(12 + i)];
        end
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        raw_c[8*i +: 8] = ebuf_r[POS_W'(8 + i)];
        if (big_endian_r) begin
          count_c[8*i +: 8] = ebuf_r[POS_W'(7 - i)];
          value_c[8*i +: 8] = ebuf_r[POS_W'(11 - i)];
        end else begin
          count_c[8*i +: 8] = ebuf_r[POS_W'(4 + i)];
          value_c[8*i +: 8] = ebuf_r[POS_W'(8 + i)];
        end
      end
    end
  end

  // widths are powers of two: keep the shift
  always_comb begin
    wzero_c  = 1'b0;
    wshift_c = 2'd0;
    case (type_c)
      FT_BYTE, FT_ASCII, FT_SBYTE, FT_UNDEFINED:   wshift_c = 2'd0;
      FT_SHORT, FT_SSHORT:                         wshift_c = 2'd1;
      FT_LONG, FT_SLONG, FT_FLOAT, FT_IFD:         wshift_c = 2'd2;
      FT_RATIONAL, FT_SRATIONAL, FT_DOUBLE,
      FT_LONG8, FT_SLONG8, FT_IFD8:                wshift_c = 2'd3;
      default:                                     wzero_c  = 1'b1;
    endcase
  end

  always_comb begin
    case (wshift_c)
      2'd0:    ovf_c = 1'b0;
      2'd1:    ovf_c = count_c[63];
      2'd2:    ovf_c = |count_c[63:62];
      default: ovf_c = |count_c[63:61];
    endcase
    bad_c = wzero_c || (!bigtiff_r && (type_c >= FT_CLASSIC_END)) ||
            (count_c == 64'd0) || ovf_c;
    total_c = bad_c ? 64'd0 : (count_c << wshift_c);
    inl_c   = !bad_c && (total_c <= {60'd0, bigtiff_r ? INL_CAP_BIG : INL_CAP_CLASSIC});
  end

  logic [15:0] d_tag_r, d_type_r;
  logic [63:0] d_count_r, d_total_r, d_value_r, d_raw_r;
  logic        d_bad_r, d_inl_r;

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      d_tag_r   <= tag_c;
      d_type_r  <= type_c;
      d_count_r <= count_c;
      d_total_r <= total_c;
      d_value_r <= value_c;
      d_raw_r   <= raw_c;
      d_bad_r   <= bad_c;
      d_inl_r   <= inl_c;
    end
  end

  // check stage: limits and bounds
  logic [64:0] end_sum;
  logic        seg_tag, icc_over, tag_over, oob;
  status_t     status_c;

  assign end_sum  = {1'b0, d_value_r} + {1'b0, d_total_r};
  assign seg_tag  = (d_tag_r == TAG_STRIP_OFS) || (d_tag_r == TAG_STRIP_COUNTS) ||
                    (d_tag_r == TAG_TILE_OFS)  || (d_tag_r == TAG_TILE_COUNTS);
  assign icc_over = (d_tag_r == TAG_ICC) && (d_total_r > max_icc_r);
  assign tag_over = !seg_tag && (d_total_r > max_tag_r);
  assign oob      = (d_value_r < header_size_r) || d_value_r[0] || end_sum[64] ||
                    (end_sum[63:0] > file_size_r);

  always_comb begin
    if (d_bad_r) begin
      status_c = STS_INVALID;
    end else if (icc_over || tag_over) begin
      status_c = STS_LIMIT;
    end else if (!d_inl_r && oob) begin
      status_c = STS_BOUNDS;
    end else begin
      status_c = STS_OK;
    end
  end

  // output register
  logic out_valid_r;

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status        <= status_c;
      out_tag_number    <= d_tag_r;
      out_field_type    <= d_type_r;
      out_element_count <= d_count_r;
      out_byte_total    <= d_total_r;
      out_value_word    <= d_value_r;
      out_inline_raw    <= d_raw_r;
      out_is_inline     <= d_inl_r;
    end
  end

endmodule

>>> design/tiff_ifd_entry_validator_unit.sv
// TIFF / BigTIFF directory entry validator.
// Input channel (in_valid/in_ready): one entry byte per word, in file order;
//   in_entry_start restarts the entry at byte 0. An entry is 12 bytes in
//   classic mode and 20 in BigTIFF mode; entries may follow back to back.
// Result channel (out_valid/out_ready): one word per complete entry with the
//   decoded tag, type, count, byte total, value/offset, raw inline bytes,
//   inline flag and a status (ok, invalid, limit exceeded, out of bounds).
// Config port: cfg_we writes cfg_data into register cfg_index (0 byte order,
//   1 BigTIFF mode, 2 header size, 3 file size, 4 ICC limit, 5 tag limit);
//   write only while no entry is in flight.
// Timing: bytes go in at one per cycle while in_ready is high. After the last
//   byte of an entry the byte buffer is decoded into the decode registers and
//   checked in the next cycle; the result is loaded once the output is free.
//   in_ready is low in the decode and check states, so the next entry's bytes
//   are taken only after the current entry has been checked and loaded.
// Stall: a held result sits in the output register while bytes of the next
//   entry keep flowing; only that entry's check cycle waits for the slot.
// Reset (rst_n low, synchronous): byte position to 0, output empty, config
//   registers to their defaults.
module tiff_ifd_entry_validator_unit
  import tifv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_entry_byte,
  input  logic        in_entry_start,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_tag_number,
  output logic [15:0] out_field_type,
  output logic [63:0] out_element_count,
  output logic [63:0] out_byte_total,
  output logic [63:0] out_value_word,
  output logic [63:0] out_inline_raw,
  output logic        out_is_inline,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: fill, decode, check
  tifv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // byte buffer, config registers, decode/check stages, output register
  tifv_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_entry_byte     (in_entry_byte),
    .in_entry_start    (in_entry_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_tag_number    (out_tag_number),
    .out_field_type    (out_field_type),
    .out_element_count (out_element_count),
    .out_byte_total    (out_byte_total),
    .out_value_word    (out_value_word),
    .out_inline_raw    (out_inline_raw),
    .out_is_inline     (out_is_inline)
  );

endmodule
